### rtl/uartrf_pkg.sv
package uartrf_pkg;

  // divider width: holds CLOCK_OVER_16 values up to 2**24 - 1, even for the radix-4 steps
  localparam int NUM_W = 24;
  localparam int CLOCK_OVER_16_DEF = 230400;
  localparam int DIVISOR_BITS_DEF = 11;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [7:0] OFF_CTRL   = 8'd0;
  localparam logic [7:0] OFF_BAUD   = 8'd4;
  localparam logic [7:0] OFF_DMABUF = 8'd8;
  localparam logic [7:0] OFF_DMALEN = 8'd12;
  localparam logic [7:0] OFF_COUNT  = 8'd16;
  localparam logic [7:0] OFF_TXHOLD = 8'd20;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_RESERVED    = 3'd1;
  localparam logic [2:0] ST_UNMODELED   = 3'd2;
  localparam logic [2:0] ST_NO_LOOP     = 3'd3;
  localparam logic [2:0] ST_BREAK       = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

  localparam logic [1:0] DK_NONE = 2'd0;
  localparam logic [1:0] DK_BUF  = 2'd1;
  localparam logic [1:0] DK_LEN  = 2'd2;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_ODD  = 2'd1;
  localparam logic [1:0] PAR_EVEN = 2'd2;

  localparam logic [31:0] CW_RESERVED  = 32'h0FFF_0000;
  localparam logic [31:0] CW_UNMODELED = 32'h0000_7810;
  localparam logic [15:0] CW_WRITABLE  = 16'h87EF;
  localparam logic [15:0] CW_RESET     = 16'h0040;
  localparam logic [31:0] BUF_ALIGN    = 32'h0000_0003;
  localparam logic [31:0] LEN_HIGH     = 32'hFFFF_0000;
  localparam logic [31:0] TX_HIGH      = 32'hFFFF_FE00;

  // control word bit positions
  localparam int CB_ENABLE   = 0;
  localparam int CB_PAR_EN   = 1;
  localparam int CB_EVEN     = 2;
  localparam int CB_SEVEN    = 3;
  localparam int CB_TWO_STOP = 5;
  localparam int CB_NO_TXD   = 6;
  localparam int CB_DMA_LOOP = 10;
  localparam int CB_DMA_RX   = 15;

  // per-access result, held while the baud division runs
  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  dma_write_kind;
    logic [31:0] dma_write_value;
  } res_t;

endpackage

### rtl/uartrf_div.sv
module uartrf_div import uartrf_pkg::*; #(
  parameter int DEN_W = DIVISOR_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  // restoring division, two quotient bits per cycle
  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;

  logic [DEN_W:0]   ra, rb, ra_sub, rb_sub;
  logic             ge_a, ge_b;
  logic [DEN_W-1:0] rem_a;

  always_comb begin
    ra     = {rem_r, q_r[NUM_W-1]};
    ra_sub = ra - {1'b0, den_r};
    ge_a   = ra >= {1'b0, den_r};
    rem_a  = ge_a ? ra_sub[DEN_W-1:0] : ra[DEN_W-1:0];
    rb     = {rem_a, q_r[NUM_W-2]};
    rb_sub = rb - {1'b0, den_r};
    ge_b   = rb >= {1'b0, den_r};
    rem_nxt = ge_b ? rb_sub[DEN_W-1:0] : rb[DEN_W-1:0];
    q_nxt   = {q_r[NUM_W-3:0], ge_a, ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= denom;
      rem_r <= '0;
      q_r   <= numer;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/uart_register_file_with_line_config.sv
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_stall    | operation, offset, write_data, rx_addr
// out_    | output    | out_valid / out_stall  | read_data, status, tx_*, line setup, dma_*
//
// out_valid rises after acceptance once the 12 radix-4 steps of the shared baud
// divider (CLOCK_OVER_16 / (divisor + 1)) are done and the output register is loaded.
// in_stall stays high from acceptance until that load, so the block takes no new item before it.
// A result held under out_stall does not block the next item; that item waits in its
// own result register once its division is done.
// Reset (rst_n, synchronous) sets the control word to 0x0040 (TXD off), divisor 0.
module uart_register_file_with_line_config import uartrf_pkg::*; #(
  parameter int CLOCK_OVER_16 = CLOCK_OVER_16_DEF,
  parameter int DIVISOR_BITS  = DIVISOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_offset,
  input  logic [31:0] in_write_data,
  input  logic [16:0] in_rx_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [2:0]  out_status,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic [17:0] out_line_baud,
  output logic [3:0]  out_char_len,
  output logic [1:0]  out_parity_mode,
  output logic        out_two_stop,
  output logic        out_dma_armed,
  output logic [1:0]  out_dma_write_kind,
  output logic [31:0] out_dma_write_value
);

  localparam int DEN_W = DIVISOR_BITS + 1;
  localparam logic [NUM_W-1:0] NUMER = NUM_W'(CLOCK_OVER_16);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for an item
  localparam logic [1:0] S_RUN  = 2'd1;  // divider busy
  localparam logic [1:0] S_HOLD = 2'd2;  // result done, output register still full

  logic [1:0]              state_r, state_nxt;
  logic [15:0]             ctl_r, ctl_nxt;
  logic [DIVISOR_BITS-1:0] div_r, div_nxt;
  res_t                    res_r, res_nxt;

  logic in_acc;
  logic slot_free;
  logic load_out;
  logic div_done;
  logic [NUM_W-1:0] quot;

  // output register
  logic        out_valid_r;
  res_t        out_res_r;
  logic [17:0] out_baud_r;
  logic [15:0] out_ctl_r;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign slot_free = !out_valid_r || !out_stall;

  // access decode: result fields and next register values
  always_comb begin
    res_nxt = '0;
    res_nxt.status = ST_OK;
    res_nxt.dma_write_kind = DK_NONE;
    ctl_nxt = ctl_r;
    div_nxt = div_r;
    if (in_operation == OP_READ) begin
      unique case (in_offset)
        OFF_CTRL: begin
          res_nxt.read_data = {ctl_r[CB_ENABLE], 1'b1, 14'd0, ctl_r & CW_WRITABLE};
        end
        OFF_COUNT: begin
          res_nxt.read_data = {15'd0, in_rx_addr};
        end
        default: res_nxt.status = ST_UNSUPPORTED;
      endcase
    end else begin
      unique case (in_offset)
        OFF_CTRL: begin
          if (|(in_write_data & CW_RESERVED))
            res_nxt.status = ST_RESERVED;
          else if (|(in_write_data & CW_UNMODELED))
            res_nxt.status = ST_UNMODELED;
          else if (in_write_data[CB_DMA_RX] && !in_write_data[CB_DMA_LOOP])
            res_nxt.status = ST_NO_LOOP;
          else
            ctl_nxt = in_write_data[15:0] & CW_WRITABLE;
        end
        OFF_BAUD: begin
          if (|(in_write_data >> DIVISOR_BITS))
            res_nxt.status = ST_RESERVED;
          else
            div_nxt = in_write_data[DIVISOR_BITS-1:0];
        end
        OFF_DMABUF: begin
          if (|(in_write_data & BUF_ALIGN)) begin
            res_nxt.status = ST_RESERVED;
          end else begin
            res_nxt.dma_write_kind  = DK_BUF;
            res_nxt.dma_write_value = in_write_data;
          end
        end
        OFF_DMALEN: begin
          if (|(in_write_data & LEN_HIGH)) begin
            res_nxt.status = ST_RESERVED;
          end else begin
            res_nxt.dma_write_kind  = DK_LEN;
            res_nxt.dma_write_value = {16'd0, in_write_data[15:0]} + 32'd1;
          end
        end
        OFF_TXHOLD: begin
          if (|(in_write_data & TX_HIGH)) begin
            res_nxt.status = ST_RESERVED;
          end else if (in_write_data[8]) begin
            res_nxt.status = ST_BREAK;
          end else if (ctl_r[CB_ENABLE] && !ctl_r[CB_NO_TXD]) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = in_write_data[7:0];
          end
        end
        default: res_nxt.status = ST_UNSUPPORTED;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RUN;
      S_RUN: begin
        if (div_done) begin
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  uartrf_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_acc),
    .numer(NUMER),
    .denom({1'b0, div_nxt} + DEN_W'(1)),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctl_r       <= CW_RESET;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ctl_r <= ctl_nxt;
        div_r <= div_nxt;
      end
      if (load_out)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc)
      res_r <= res_nxt;
    if (load_out) begin
      out_res_r  <= res_r;
      out_baud_r <= quot[17:0];
      out_ctl_r  <= ctl_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_res_r.read_data;
  assign out_status          = out_res_r.status;
  assign out_tx_valid        = out_res_r.tx_valid;
  assign out_tx_byte         = out_res_r.tx_byte;
  assign out_dma_write_kind  = out_res_r.dma_write_kind;
  assign out_dma_write_value = out_res_r.dma_write_value;
  assign out_line_baud       = out_baud_r;
  assign out_char_len        = out_ctl_r[CB_SEVEN] ? 4'd7 : 4'd8;
  assign out_parity_mode     = !out_ctl_r[CB_PAR_EN] ? PAR_NONE :
                               (out_ctl_r[CB_EVEN] ? PAR_EVEN : PAR_ODD);
  assign out_two_stop        = out_ctl_r[CB_TWO_STOP];
  assign out_dma_armed       = out_ctl_r[CB_DMA_RX];

endmodule

### tb/tb_top.sv
module tb_top import uartrf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Local codes and masks not spelled out in the package
  // ---------------------------------------------------------------------------
  localparam logic [31:0] EMPTY_BIT  = 32'h4000_0000;  // always set on a control read
  localparam logic [31:0] UARTON_BIT = 32'h8000_0000;  // follows the enable bit
  localparam int          TX_BREAK   = 8;              // break request in the hold word
  localparam logic [31:0] DIV_MASK   = (32'd1 << DIVISOR_BITS_DEF) - 32'd1;
  localparam int          RUN_ITEMS  = 650;

  // receiver stall behavior, re-picked whenever rcv_cycle wraps to zero
  typedef enum logic [1:0] {
    RCV_FREE,    // never stalls
    RCV_RANDOM,  // stalls about a third of the cycles
    RCV_RUNS     // alternating runs of stall / no stall, each of random length
  } rcv_mode_t;

  // one bus access as queued for the driver
  typedef struct packed {
    logic        drain;   // hold this item until every pending reply has come back
    logic        op;
    logic [7:0]  off;
    logic [31:0] wdata;
    logic [16:0] cnt;
  } access_t;

  // one reply, in the order of the result ports
  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [17:0] line_baud;
    logic [3:0]  char_len;
    logic [1:0]  parity_mode;
    logic        two_stop;
    logic        dma_armed;
    logic [1:0]  dma_write_kind;
    logic [31:0] dma_write_value;
  } reply_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_READ;
  logic [7:0]  in_offset = 8'd0;
  logic [31:0] in_write_data = 32'd0;
  logic [16:0] in_rx_addr = 17'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic [2:0]  out_status;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic [17:0] out_line_baud;
  logic [3:0]  out_char_len;
  logic [1:0]  out_parity_mode;
  logic        out_two_stop;
  logic        out_dma_armed;
  logic [1:0]  out_dma_write_kind;
  logic [31:0] out_dma_write_value;

  always #5 clk = ~clk;

  uart_register_file_with_line_config dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_offset           (in_offset),
    .in_write_data       (in_write_data),
    .in_rx_addr          (in_rx_addr),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_status          (out_status),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_line_baud       (out_line_baud),
    .out_char_len        (out_char_len),
    .out_parity_mode     (out_parity_mode),
    .out_two_stop        (out_two_stop),
    .out_dma_armed       (out_dma_armed),
    .out_dma_write_kind  (out_dma_write_kind),
    .out_dma_write_value (out_dma_write_value)
  );

  // ---------------------------------------------------------------------------
  // Register-file model: shadow copies of the control word and divisor
  // ---------------------------------------------------------------------------
  logic [15:0] ctrl_shadow = CW_RESET;
  logic [10:0] div_shadow  = '0;

  // Applies one access to the shadow registers and returns the reply the
  // block must give. Line setup is taken after the access.
  function automatic reply_t predict_access(logic op, logic [7:0] off, logic [31:0] v,
                                            logic [16:0] cnt);
    reply_t      r;
    int unsigned baud_full;
    r = '0;
    if (op == OP_READ) begin
      if (off == OFF_CTRL) begin
        r.read_data = {16'h0000, ctrl_shadow & CW_WRITABLE} | EMPTY_BIT;
        if (ctrl_shadow[CB_ENABLE]) r.read_data = r.read_data | UARTON_BIT;
      end else if (off == OFF_COUNT) begin
        r.read_data = {15'h0000, cnt};
      end else begin
        r.status = ST_UNSUPPORTED;   // write-only or unknown register
      end
    end else begin
      case (off)
        OFF_CTRL: begin
          // priority: reserved, then unmodeled, then DMA without loop
          if ((v & CW_RESERVED) != 0) r.status = ST_RESERVED;
          else if ((v & CW_UNMODELED) != 0) r.status = ST_UNMODELED;
          else if (v[CB_DMA_RX] && !v[CB_DMA_LOOP]) r.status = ST_NO_LOOP;
          else ctrl_shadow = v[15:0] & CW_WRITABLE;
        end
        OFF_BAUD: begin
          if ((v & ~DIV_MASK) != 0) r.status = ST_RESERVED;
          else div_shadow = v[DIVISOR_BITS_DEF-1:0];
        end
        OFF_DMABUF: begin
          if ((v & BUF_ALIGN) != 0) begin
            r.status = ST_RESERVED;
          end else begin
            r.dma_write_kind  = DK_BUF;
            r.dma_write_value = v;
          end
        end
        OFF_DMALEN: begin
          if ((v & LEN_HIGH) != 0) begin
            r.status = ST_RESERVED;
          end else begin
            r.dma_write_kind  = DK_LEN;
            r.dma_write_value = {16'h0000, v[15:0]} + 32'd1;
          end
        end
        OFF_TXHOLD: begin
          if ((v & TX_HIGH) != 0) begin
            r.status = ST_RESERVED;
          end else if (v[TX_BREAK]) begin
            r.status = ST_BREAK;
          end else if (ctrl_shadow[CB_ENABLE] && !ctrl_shadow[CB_NO_TXD]) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = v[7:0];
          end
        end
        default: r.status = ST_UNSUPPORTED;   // includes a write of the count
      endcase
    end
    baud_full = CLOCK_OVER_16_DEF / (int'(div_shadow) + 1);
    r.line_baud = baud_full[17:0];
    r.char_len  = ctrl_shadow[CB_SEVEN] ? 4'd7 : 4'd8;
    if (!ctrl_shadow[CB_PAR_EN]) r.parity_mode = PAR_NONE;
    else r.parity_mode = ctrl_shadow[CB_EVEN] ? PAR_EVEN : PAR_ODD;
    r.two_stop  = ctrl_shadow[CB_TWO_STOP];
    r.dma_armed = ctrl_shadow[CB_DMA_RX];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  access_t pending_q[$];   // accesses not yet presented to the block
  reply_t  reply_q[$];     // replies owed by the block, oldest first

  function automatic access_t bus_access(logic op, logic [7:0] off, logic [31:0] wd,
                                         logic [16:0] cnt, logic drain);
    access_t a;
    a.drain = drain;
    a.op    = op;
    a.off   = off;
    a.wdata = wd;
    a.cnt   = cnt;
    return a;
  endfunction

  // Mostly well-formed accesses with random content, some noise on top.
  function automatic access_t random_access();
    access_t     a;
    int          pick;
    int          sub;
    logic [31:0] v;
    a       = '0;
    a.cnt   = 17'($urandom_range(0, 65536));
    a.wdata = $urandom;
    pick    = $urandom_range(0, 99);
    sub     = $urandom_range(0, 99);
    if (pick < 30) begin
      a.op = OP_READ;
      if (sub < 50) a.off = OFF_CTRL;
      else if (sub < 90) a.off = OFF_COUNT;
      else a.off = 8'($urandom);
    end else if (pick < 37) begin
      // pure noise: any op, any offset, any word
      a.op  = 1'($urandom);
      a.off = 8'($urandom);
    end else begin
      a.op = OP_WRITE;
      if (sub < 25) begin
        a.off = OFF_CTRL;
        v = ($urandom & 32'h0000_87EF) | ($urandom & 32'hF000_0000);
        // keep the UART enabled with TXD connected most of the time
        if ($urandom_range(0, 9) < 7) begin
          v[CB_ENABLE] = 1'b1;
          v[CB_NO_TXD] = 1'b0;
        end
        if (v[CB_DMA_RX] && $urandom_range(0, 3) != 0) v[CB_DMA_LOOP] = 1'b1;
        if ($urandom_range(0, 9) == 0) v = v | (32'd1 << $urandom_range(4, 27));
        a.wdata = v;
      end else if (sub < 40) begin
        a.off = OFF_BAUD;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: a.wdata = $urandom_range(0, 15);
          6, 7, 8:          a.wdata = $urandom_range(0, 2047);
          default:          a.wdata = $urandom;
        endcase
      end else if (sub < 50) begin
        a.off = OFF_DMABUF;
        if ($urandom_range(0, 4) != 0) a.wdata = $urandom & ~BUF_ALIGN;
      end else if (sub < 60) begin
        a.off = OFF_DMALEN;
        if ($urandom_range(0, 4) != 0) a.wdata = $urandom_range(0, 65535);
      end else begin
        a.off = OFF_TXHOLD;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6, 7: a.wdata = $urandom_range(0, 255);
          8:                      a.wdata = 32'h100 | $urandom_range(0, 255);
          default:                a.wdata = $urandom;
        endcase
      end
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items at the falling edge, in bursts with gaps.
  // in_took says whether the item shown last was taken at the rising edge.
  // ---------------------------------------------------------------------------
  logic    in_took = 1'b0;
  int      burst_left = 8;
  int      gap_left = 0;
  access_t drv_item;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // held under in_stall: payload stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].drain && reply_q.size() != 0)) begin
      // nothing left, or a drain point waiting for the block to empty
      in_valid <= 1'b0;
    end else begin
      drv_item = pending_q.pop_front();
      in_valid      <= 1'b1;
      in_operation  <= drv_item.op;
      in_offset     <= drv_item.off;
      in_write_data <= drv_item.wdata;
      in_rx_addr    <= drv_item.cnt;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        // a quarter of the bursts run back to back with no gap at all
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_stall on its own pattern, changed at the falling edge
  // ---------------------------------------------------------------------------
  rcv_mode_t rcv_mode = RCV_FREE;
  int        rcv_cycle = 0;
  int        rcv_run = 0;
  logic      rcv_level = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rcv_cycle == 0) rcv_mode = rcv_mode_t'($urandom_range(0, 2));
      rcv_cycle = (rcv_cycle + 1) % 256;
      case (rcv_mode)
        RCV_FREE:   out_stall <= 1'b0;
        RCV_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (rcv_run == 0) begin
            rcv_run   = $urandom_range(1, 20);
            rcv_level = ~rcv_level;
          end
          rcv_run = rcv_run - 1;
          out_stall <= rcv_level;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks replies against the oldest owed one, then predicts the
  // reply for any item taken at this edge.
  // ---------------------------------------------------------------------------
  int     errors = 0;
  int     accesses = 0;
  int     bytes_sent = 0;
  int     status_seen[6] = '{default: 0};
  reply_t got;
  reply_t want;

  function automatic string reply_text(reply_t r);
    return $sformatf({"rd=%h st=%0d txv=%b txb=%h baud=%0d bits=%0d par=%0d ",
                      "stop2=%b dma=%b dk=%0d dv=%h"},
                     r.read_data, r.status, r.tx_valid, r.tx_byte, r.line_baud,
                     r.char_len, r.parity_mode, r.two_stop, r.dma_armed,
                     r.dma_write_kind, r.dma_write_value);
  endfunction

  task automatic report_mismatch(string what, reply_t exp_r, reply_t got_r);
    errors = errors + 1;
    if (errors <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected %s", reply_text(exp_r));
      $display("  actual   %s", reply_text(got_r));
    end
  endtask

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_read_data, out_status, out_tx_valid, out_tx_byte, out_line_baud,
             out_char_len, out_parity_mode, out_two_stop, out_dma_armed,
             out_dma_write_kind, out_dma_write_value};
      if (reply_q.size() == 0) begin
        report_mismatch("reply with no access outstanding", '0, got);
      end else begin
        want = reply_q.pop_front();
        if (got !== want) report_mismatch("reply mismatch", want, got);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want = predict_access(in_operation, in_offset, in_write_data, in_rx_addr);
      reply_q.push_back(want);
      accesses = accesses + 1;
      if (want.tx_valid) bytes_sent = bytes_sent + 1;
      status_seen[want.status] = status_seen[want.status] + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed accesses, random accesses, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    access_t a;
    // directed part, starting from the reset state
    pending_q.push_back(bus_access(OP_READ,  OFF_CTRL,   32'h0000_0000, 17'd0, 1'b0));
    // TXD disconnected after reset: nothing goes out
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'h0000_0041, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0001_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0800_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0000_0010, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0000_4000, 17'd0, 1'b0));
    // receive DMA without looping is refused
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0000_8000, 17'd0, 1'b0));
    // all writable bits plus the read-only top nibble, which is ignored
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'hF000_87EF, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_READ,  OFF_CTRL,   32'hFFFF_FFFF, 17'd0, 1'b0));
    // enabled, odd parity, TXD connected
    pending_q.push_back(bus_access(OP_WRITE, OFF_CTRL,   32'h0000_0003, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'h0000_00FF, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'h0000_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'h0000_0100, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'h0000_0200, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_TXHOLD, 32'hFFFF_FFFF, 17'd0, 1'b0));
    // divisor extremes: slowest line, then out of range, then fastest
    pending_q.push_back(bus_access(OP_WRITE, OFF_BAUD,   32'h0000_07FF, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_BAUD,   32'h0000_0800, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_READ,  OFF_BAUD,   32'h0000_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_BAUD,   32'h0000_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_DMABUF, 32'hFFFF_FFFC, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_DMABUF, 32'h0000_0001, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_DMALEN, 32'h0000_FFFF, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, OFF_DMALEN, 32'h0001_0000, 17'd0, 1'b0));
    // counter read at its top value, issued only once the block has emptied
    pending_q.push_back(bus_access(OP_READ,  OFF_COUNT,  32'h0000_0000, 17'd65536, 1'b1));
    pending_q.push_back(bus_access(OP_WRITE, OFF_COUNT,  32'h0000_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_READ,  8'hFF,      32'h0000_0000, 17'd0, 1'b0));
    pending_q.push_back(bus_access(OP_WRITE, 8'h01,      32'h0000_0041, 17'd0, 1'b0));

    // random part, with two more drain points along the way
    for (int i = 0; i < RUN_ITEMS; i++) begin
      a = random_access();
      if (i == 300 || i == 500) a.drain = 1'b1;
      pending_q.push_back(a);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // everything handed over, then every reply back, then a quiet tail
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d accesses, %0d bytes sent to the line.", accesses, bytes_sent);
    $display("Status mix: ok %0d, reserved %0d, unmodeled %0d, no-loop %0d, break %0d, %s %0d.",
             status_seen[ST_OK], status_seen[ST_RESERVED], status_seen[ST_UNMODELED],
             status_seen[ST_NO_LOOP], status_seen[ST_BREAK], "unsupported",
             status_seen[ST_UNSUPPORTED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
